// ----- rtl/sli_pkg.sv -----
package sli_pkg;

  // width of each result coordinate
  localparam int OUT_BITS = 32;

  // query kind carried with each word
  typedef enum logic {
    CMD_SEGMENT = 1'b0,
    CMD_LINE    = 1'b1
  } cmd_t;

endpackage

// ----- rtl/sli_req_if.sv -----
interface sli_req_if
  import sli_pkg::*;
#(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  cmd_t                         cmd;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] dx;
  logic signed [COORD_BITS-1:0] dy;

  modport source (output valid, cmd, ax, ay, bx, by, cx, cy, dx, dy, input ready);
  modport sink   (input valid, cmd, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

// ----- rtl/sli_rsp_if.sv -----
interface sli_rsp_if
  import sli_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic signed [OUT_BITS-1:0] point_x;
  logic signed [OUT_BITS-1:0] point_y;
  logic                       saturated;

  modport source (output valid, hit, point_x, point_y, saturated, input ready);
  modport sink   (input valid, hit, point_x, point_y, saturated, output ready);
endinterface

// ----- rtl/segment_line_intersection_core.sv -----
// channel | dir | word contents
// req     | in  | cmd, ax, ay, bx, by, cx, cy, dx, dy (COORD_BITS signed each)
// rsp     | out | hit, point_x, point_y (32 bit signed), saturated
//
// one word accepted per cycle while rsp is not stalled; each result passes through
// the stage registers and then the one-quotient-bit-per-stage dividers
// rst is synchronous and clears only the stage valid bits
// a stall on rsp freezes the whole pipeline; req.ready drops with it
module segment_line_intersection_core
  import sli_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  sli_req_if.sink    req,
  sli_rsp_if.source  rsp
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;          // coordinate differences
  localparam int PW = 2 * DW;          // difference products
  localparam int RW = PW + 1;          // rs, tn, un
  localparam int LW = RW / 2;          // low part of a split operand
  localparam int HW = RW - LW;         // high part, signed
  localparam int NW = RW + DW + 1;     // numerator A*rs + tn*R
  localparam int OB = OUT_BITS;
  localparam int MW = (NW > OB + RW) ? NW : OB + RW;

  // one divider lane: partial remainder, numerator bits still to feed, quotient
  typedef struct packed {
    logic [RW-2:0] rem;
    logic [OB-1:0] low;
    logic [OB-1:0] q;
  } lane_t;

  function automatic lane_t div_step(lane_t d, logic [RW-2:0] den);
    lane_t         r;
    logic [RW-1:0] t;
    logic [RW-1:0] diff;
    logic          ge;
    t     = {d.rem, d.low[OB-1]};
    diff  = t - {1'b0, den};
    ge    = t >= {1'b0, den};
    r.rem = ge ? diff[RW-2:0] : t[RW-2:0];
    r.low = {d.low[OB-2:0], 1'b0};
    r.q   = {d.q[OB-2:0], ge};
    return r;
  endfunction

  // whole pipe moves together; advance when the output slot is free or taken
  logic adv;
  logic vout;
  assign adv       = !vout || rsp.ready;
  assign req.ready = adv;

  // stage valid bits
  logic [8:1] v;
  logic [OB:0] vd;

  // stage 1: differences
  cmd_t                 cmd1;
  logic signed [CB-1:0] ax1, ay1;
  logic signed [DW-1:0] rx1, ry1, sx1, sy1, qx1, qy1;

  // stage 2: six products
  cmd_t                 cmd2;
  logic signed [CB-1:0] ax2, ay2;
  logic signed [DW-1:0] rx2, ry2;
  logic signed [PW-1:0] m_rsa, m_rsb, m_tna, m_tnb, m_una, m_unb;

  // stage 3: cross products
  cmd_t                 cmd3;
  logic signed [CB-1:0] ax3, ay3;
  logic signed [DW-1:0] rx3, ry3;
  logic signed [RW-1:0] rs3, tn3, un3;

  // stage 4: sign normalised so that rs is not negative
  cmd_t                 cmd4;
  logic                 nz4;
  logic signed [CB-1:0] ax4, ay4;
  logic signed [DW-1:0] rx4, ry4;
  logic signed [RW-1:0] rs4, tn4, un4;

  // stage 5: hit decision and split partial products
  logic                    hit5;
  logic [RW-2:0]           den5;
  logic signed [CB+HW-1:0] pah_x, pah_y;
  logic signed [CB+LW:0]   pal_x, pal_y;
  logic signed [DW+HW-1:0] pbh_x, pbh_y;
  logic signed [DW+LW:0]   pbl_x, pbl_y;

  // stage 6: partial products joined
  logic                 hit6;
  logic [RW-2:0]        den6;
  logic signed [NW-1:0] pa_x, pa_y, pb_x, pb_y;

  // stage 7: numerators
  logic                 hit7;
  logic [RW-2:0]        den7;
  logic signed [NW-1:0] num_x, num_y;

  // stage 8: magnitudes
  logic          hit8, neg_x8, neg_y8;
  logic [RW-2:0] den8;
  logic [MW-1:0] mag_x8, mag_y8;

  // divider stages, index 0 is the load stage
  lane_t         dvx [0:OB];
  lane_t         dvy [0:OB];
  logic [RW-2:0] den_d [0:OB];
  logic          hit_d [0:OB];
  logic          negx_d [0:OB];
  logic          negy_d [0:OB];
  logic          ovfx_d [0:OB];
  logic          ovfy_d [0:OB];

  // output word
  logic                 hit_o, sat_o;
  logic signed [OB-1:0] px_o, py_o;

  // final clamp and sign
  logic [OB-1:0] lim_x, lim_y, val_x, val_y;
  logic          sat_x, sat_y;

  always_comb begin
    lim_x = negx_d[OB] ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}};
    lim_y = negy_d[OB] ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}};
    sat_x = ovfx_d[OB] || (dvx[OB].q > lim_x);
    sat_y = ovfy_d[OB] || (dvy[OB].q > lim_y);
    val_x = sat_x ? lim_x : dvx[OB].q;
    val_y = sat_y ? lim_y : dvy[OB].q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      vd   <= '0;
      vout <= 1'b0;
    end else if (adv) begin
      v    <= {v[7:1], req.valid};
      vd   <= {vd[OB-1:0], v[8]};
      vout <= vd[OB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      cmd1 <= req.cmd;
      ax1  <= req.ax;
      ay1  <= req.ay;
      rx1  <= DW'(req.bx) - DW'(req.ax);
      ry1  <= DW'(req.by) - DW'(req.ay);
      sx1  <= DW'(req.dx) - DW'(req.cx);
      sy1  <= DW'(req.dy) - DW'(req.cy);
      qx1  <= DW'(req.cx) - DW'(req.ax);
      qy1  <= DW'(req.cy) - DW'(req.ay);

      // stage 2
      cmd2  <= cmd1;
      ax2   <= ax1;
      ay2   <= ay1;
      rx2   <= rx1;
      ry2   <= ry1;
      m_rsa <= rx1 * sy1;
      m_rsb <= ry1 * sx1;
      m_tna <= qx1 * sy1;
      m_tnb <= qy1 * sx1;
      m_una <= qx1 * ry1;
      m_unb <= qy1 * rx1;

      // stage 3
      cmd3 <= cmd2;
      ax3  <= ax2;
      ay3  <= ay2;
      rx3  <= rx2;
      ry3  <= ry2;
      rs3  <= RW'(m_rsa) - RW'(m_rsb);
      tn3  <= RW'(m_tna) - RW'(m_tnb);
      un3  <= RW'(m_una) - RW'(m_unb);

      // stage 4: flip all three together when rs is negative
      cmd4 <= cmd3;
      nz4  <= rs3 != '0;
      ax4  <= ax3;
      ay4  <= ay3;
      rx4  <= rx3;
      ry4  <= ry3;
      rs4  <= rs3[RW-1] ? -rs3 : rs3;
      tn4  <= rs3[RW-1] ? -tn3 : tn3;
      un4  <= rs3[RW-1] ? -un3 : un3;

      // stage 5: lines hit when rs is non-zero; segments also need 0 <= t,u <= 1 as 0 <= tn,un <= rs
      hit5  <= nz4 && (cmd4 == CMD_LINE ||
                       (!tn4[RW-1] && tn4 <= rs4 && !un4[RW-1] && un4 <= rs4));
      den5  <= rs4[RW-2:0];
      pah_x <= ax4 * $signed(rs4[RW-1:LW]);
      pah_y <= ay4 * $signed(rs4[RW-1:LW]);
      pal_x <= ax4 * $signed({1'b0, rs4[LW-1:0]});
      pal_y <= ay4 * $signed({1'b0, rs4[LW-1:0]});
      pbh_x <= rx4 * $signed(tn4[RW-1:LW]);
      pbh_y <= ry4 * $signed(tn4[RW-1:LW]);
      pbl_x <= rx4 * $signed({1'b0, tn4[LW-1:0]});
      pbl_y <= ry4 * $signed({1'b0, tn4[LW-1:0]});

      // stage 6
      hit6 <= hit5;
      den6 <= den5;
      pa_x <= (NW'(pah_x) <<< LW) + NW'(pal_x);
      pa_y <= (NW'(pah_y) <<< LW) + NW'(pal_y);
      pb_x <= (NW'(pbh_x) <<< LW) + NW'(pbl_x);
      pb_y <= (NW'(pbh_y) <<< LW) + NW'(pbl_y);

      // stage 7: numerator of A + t*R over rs
      hit7  <= hit6;
      den7  <= den6;
      num_x <= pa_x + pb_x;
      num_y <= pa_y + pb_y;

      // stage 8
      hit8   <= hit7;
      den8   <= den7;
      neg_x8 <= num_x[NW-1];
      neg_y8 <= num_y[NW-1];
      mag_x8 <= MW'($unsigned(num_x[NW-1] ? -num_x : num_x));
      mag_y8 <= MW'($unsigned(num_y[NW-1] ? -num_y : num_y));

      // divider load: quotient of 2^OB or more is flagged, the rest is exact
      hit_d[0]   <= hit8;
      den_d[0]   <= den8;
      negx_d[0]  <= neg_x8;
      negy_d[0]  <= neg_y8;
      ovfx_d[0]  <= mag_x8[MW-1:OB] >= (MW-OB)'(den8);
      ovfy_d[0]  <= mag_y8[MW-1:OB] >= (MW-OB)'(den8);
      dvx[0].rem <= mag_x8[OB+RW-2:OB];
      dvx[0].low <= mag_x8[OB-1:0];
      dvx[0].q   <= '0;
      dvy[0].rem <= mag_y8[OB+RW-2:OB];
      dvy[0].low <= mag_y8[OB-1:0];
      dvy[0].q   <= '0;

      // output word, zeroed on a miss
      hit_o <= hit_d[OB];
      sat_o <= hit_d[OB] && (sat_x || sat_y);
      px_o  <= hit_d[OB] ? (negx_d[OB] ? -val_x : val_x) : '0;
      py_o  <= hit_d[OB] ? (negy_d[OB] ? -val_y : val_y) : '0;
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= OB; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dvx[j]    <= div_step(dvx[j-1], den_d[j-1]);
        dvy[j]    <= div_step(dvy[j-1], den_d[j-1]);
        den_d[j]  <= den_d[j-1];
        hit_d[j]  <= hit_d[j-1];
        negx_d[j] <= negx_d[j-1];
        negy_d[j] <= negy_d[j-1];
        ovfx_d[j] <= ovfx_d[j-1];
        ovfy_d[j] <= ovfy_d[j-1];
      end
    end
  end

  assign rsp.valid     = vout;
  assign rsp.hit       = hit_o;
  assign rsp.point_x   = px_o;
  assign rsp.point_y   = py_o;
  assign rsp.saturated = sat_o;

endmodule

// ----- rtl/sli_checker.sv -----
module sli_checker
  import sli_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic                       hit,
  input logic signed [OUT_BITS-1:0] point_x,
  input logic signed [OUT_BITS-1:0] point_y,
  input logic                       saturated
);

  // a held result keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_x) && $stable(point_y)
      && $stable(hit) && $stable(saturated))
    else $error("held result changed");

  // a full, stalled output blocks new words
  a_back: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("word taken while output stalled");

  // a miss carries zeros
  a_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !hit |-> point_x == '0 && point_y == '0 && !saturated)
    else $error("miss with non-zero fields");

  // clamping only on a hit
  a_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && saturated |-> hit)
    else $error("saturated without hit");

  // reset empties the pipe
  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind segment_line_intersection_core sli_checker u_sli_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .hit       (rsp.hit),
  .point_x   (rsp.point_x),
  .point_y   (rsp.point_y),
  .saturated (rsp.saturated)
);

// ----- bench/geometry_scoreboard.sv -----
// expected intersection results for the segment/line core
class geometry_scoreboard;
  typedef struct {
    logic               hit;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sat;
  } answer_t;

  answer_t pending[$];
  int      errors;
  int      checked;
  int      hits;
  int      sats;

  // exact quotient of num/den (den > 0), truncated toward zero, clamped to 32 bits
  function automatic logic signed [31:0] clamp_quot(logic signed [127:0] num,
                                                     logic signed [127:0] den,
                                                     ref logic sat);
    logic signed [127:0] q;
    q = num / den;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function void note_query(sli_pkg::cmd_t cmd, logic signed [15:0] ax, logic signed [15:0] ay,
                           logic signed [15:0] bx, logic signed [15:0] by,
                           logic signed [15:0] cx, logic signed [15:0] cy,
                           logic signed [15:0] dx, logic signed [15:0] dy);
    logic signed [127:0] rx, ry, sx, sy, qx, qy, rs, tn, un;
    answer_t a;
    logic sat;
    rx = bx - ax; ry = by - ay;
    sx = dx - cx; sy = dy - cy;
    qx = cx - ax; qy = cy - ay;
    rs = rx * sy - ry * sx;
    tn = qx * sy - qy * sx;
    un = qx * ry - qy * rx;
    a = '{1'b0, 32'sd0, 32'sd0, 1'b0};
    sat = 1'b0;
    if (rs != 0) begin
      if (rs < 0) begin
        rs = -rs; tn = -tn; un = -un;
      end
      if (!(cmd == sli_pkg::CMD_SEGMENT && (tn < 0 || tn > rs || un < 0 || un > rs))) begin
        a.hit = 1'b1;
        a.px  = clamp_quot(ax * rs + tn * rx, rs, sat);
        a.py  = clamp_quot(ay * rs + tn * ry, rs, sat);
        a.sat = sat;
      end
    end
    pending.push_back(a);
  endfunction

  function void check_result(logic hit, logic signed [31:0] px, logic signed [31:0] py,
                             logic sat);
    answer_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result hit=%0b x=%0d y=%0d sat=%0b", $time, hit, px, py, sat);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (hit) hits++;
    if (sat) sats++;
    if (hit !== e.hit) begin
      $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
      errors++;
    end
    if (px !== e.px) begin
      $display("%0t: point_x expected %0d actual %0d", $time, e.px, px);
      errors++;
    end
    if (py !== e.py) begin
      $display("%0t: point_y expected %0d actual %0d", $time, e.py, py);
      errors++;
    end
    if (sat !== e.sat) begin
      $display("%0t: saturated expected %0b actual %0b", $time, e.sat, sat);
      errors++;
    end
  endfunction
endclass

// ----- bench/testbench.sv -----
module testbench;
  import sli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = OUT_BITS + 9;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sli_req_if #(.COORD_BITS(16)) req ();
  sli_rsp_if                    rsp ();

  segment_line_intersection_core #(.COORD_BITS(16)) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #10 clk = ~clk;

  geometry_scoreboard intersections = new();

  int  sent;
  int  idle_cycles;
  bit  hold_off_done;

  // a query word: cmd then the four points
  typedef struct {
    cmd_t               cmd;
    logic signed [15:0] p[8];
  } query_t;

  // after a random gap, offer one word, wait for acceptance, then note it
  task automatic send_query(query_t q);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= q.cmd;
    req.ax <= q.p[0]; req.ay <= q.p[1]; req.bx <= q.p[2]; req.by <= q.p[3];
    req.cx <= q.p[4]; req.cy <= q.p[5]; req.dx <= q.p[6]; req.dy <= q.p[7];
    do @(posedge clk); while (!req.ready);
    intersections.note_query(q.cmd, q.p[0], q.p[1], q.p[2], q.p[3],
                             q.p[4], q.p[5], q.p[6], q.p[7]);
    sent++;
    @(negedge clk);
  endtask

  // directed query from eight coordinates
  task automatic send_points(cmd_t c, int a0, int a1, int a2, int a3,
                             int a4, int a5, int a6, int a7);
    query_t q;
    q.cmd = c;
    q.p[0] = 16'(a0); q.p[1] = 16'(a1); q.p[2] = 16'(a2); q.p[3] = 16'(a3);
    q.p[4] = 16'(a4); q.p[5] = 16'(a5); q.p[6] = 16'(a6); q.p[7] = 16'(a7);
    send_query(q);
  endtask

  // random coordinate: half the time full range, else near the extremes or small
  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'(16'sh8000 + $urandom_range(0, 3));
      1: return 16'(16'sh7fff - $urandom_range(0, 3));
      2: return 16'($urandom_range(0, 40) - 20);
      default: return 16'($urandom());
    endcase
  endfunction

  // receiver: random stall per word, and one long hold-off early on
  initial begin
    int stall;
    rsp.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!hold_off_done && sent > 40) begin
        rsp.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off_done = 1'b1;
      end
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // compare each accepted result word at the rising edge
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      intersections.check_result(rsp.hit, rsp.point_x, rsp.point_y, rsp.saturated);
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    query_t q;
    req.valid = 1'b0;
    req.cmd   = CMD_SEGMENT;
    {req.ax, req.ay, req.bx, req.by, req.cx, req.cy, req.dx, req.dy} = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // crossing segments, plain hit in both modes
    send_points(CMD_SEGMENT, 0, 0, 10, 10, 0, 10, 10, 0);
    send_points(CMD_LINE,    0, 0, 10, 10, 0, 10, 10, 0);
    // parallel and collinear give no hit
    send_points(CMD_SEGMENT, 0, 0, 10, 0, 0, 5, 10, 5);
    send_points(CMD_LINE,    0, 0, 10, 10, 20, 20, 30, 30);
    // degenerate segment of zero length
    send_points(CMD_LINE,    3, 3, 3, 3, 0, 10, 10, 0);
    // segments miss but the lines meet
    send_points(CMD_SEGMENT, 0, 0, 1, 1, 10, 0, 11, -1);
    send_points(CMD_LINE,    0, 0, 1, 1, 10, 0, 11, -1);
    // touching at an end point, t and u exactly 0 or 1
    send_points(CMD_SEGMENT, 0, 0, 4, 0, 4, 0, 4, 9);
    send_points(CMD_SEGMENT, 0, 0, 4, 0, 0, -3, 0, 0);
    // negative, non integral points truncate toward zero
    send_points(CMD_LINE,    0, 0, -3, -1, 0, -1, -1, 0);
    send_points(CMD_SEGMENT, -7, 0, 0, -3, -7, -3, 0, 0);
    // extremes of the coordinate range
    send_points(CMD_SEGMENT, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_points(CMD_LINE,    32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    // lines at a shallow angle meet outside the 16-bit coordinate range, in both directions
    send_points(CMD_LINE,    -32768, 0, 32767, 1, -32768, 2, 32767, 2);
    send_points(CMD_LINE,    32767, 0, -32768, 1, 32767, 2, -32768, 2);
    send_points(CMD_LINE,    0, -32768, 1, 32767, 2, -32768, 2, 32767);
    send_points(CMD_LINE,    0, 32767, 1, -32768, -2, 32767, -2, -32768);

    // random part: mostly points around a common centre, some with parallel segments, some pure noise
    repeat (500) begin
      q.cmd = cmd_t'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
        foreach (q.p[i]) q.p[i] = pick_coord();
      end else begin
        int cx0, cy0, span;
        cx0  = $signed($urandom_range(0, 65535)) - 32768;
        cy0  = $signed($urandom_range(0, 65535)) - 32768;
        span = 1 << $urandom_range(1, 15);
        foreach (q.p[i])
          q.p[i] = 16'(((i % 2) ? cy0 : cx0) + $signed($urandom_range(0, 2 * span)) - span);
        if ($urandom_range(0, 7) == 0) begin
          q.p[6] = q.p[4] + q.p[2] - q.p[0];
          q.p[7] = q.p[5] + q.p[3] - q.p[1];
        end
      end
      send_query(q);
    end
    req.valid <= 1'b0;

    wait (intersections.pending.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d queries, %0d results checked, %0d hits, %0d saturated",
             sent, intersections.checked, intersections.hits, intersections.sats);
    if (intersections.errors == 0 && intersections.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
